@@ rtl/clc_pkg.sv @@
// Shared types and constants for the connector latch controller.
`default_nettype none

package clc_pkg;

  // Widths of the transaction fields and per-connector counters.
  localparam int MAP_W = 10;
  localparam int CNT_W = 11;
  localparam int ACT_W = 4;
  localparam int LIM_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register reset values.
  localparam logic [ACT_W-1:0] ACTIVE_RESET  = 4'd10;
  localparam logic [LIM_W-1:0] LIMIT_RESET   = 10'd100;
  localparam logic [LIM_W-1:0] TIMEOUT_RESET = 10'd100;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_CONNECTORS = 2'd0,
    CFG_BAD_LOCK_LIMIT    = 2'd1,
    CFG_RELEASE_TIMEOUT   = 2'd2
  } cfg_index_t;

  // Per-tick control that the top level hands to one lane.
  typedef struct packed {
    logic active;
    logic present;
    logic mark;
  } lane_ctrl_t;

  // Stored flags of one lane before the tick.
  typedef struct packed {
    logic locked;
    logic pending;
  } lane_state_t;

  // What one lane found for the current tick.
  typedef struct packed {
    logic lock_pulse;
    logic unlock_pulse;
    logic locked_next;
    logic pending_next;
  } lane_result_t;

endpackage

`default_nettype wire

@@ rtl/clc_if.sv @@
// Handshake interfaces for the tick, result and configuration channels.
`default_nettype none

interface clc_in_if;
  import clc_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAP_W-1:0] presence_map;
  logic             release_request;
  modport source(output valid, presence_map, release_request, input ready);
  modport sink(input valid, presence_map, release_request, output ready);
endinterface

interface clc_out_if;
  import clc_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAP_W-1:0] lock_pulses;
  logic [MAP_W-1:0] unlock_pulses;
  logic [MAP_W-1:0] locked_map;
  logic [MAP_W-1:0] release_pending_map;
  modport source(output valid, lock_pulses, unlock_pulses, locked_map,
                 release_pending_map, input ready);
  modport sink(input valid, lock_pulses, unlock_pulses, locked_map,
               release_pending_map, output ready);
endinterface

interface clc_cfg_if;
  import clc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LIM_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/clc_pick.sv @@
// Release request arbiter: marks the lowest-numbered eligible connector.
`default_nettype none

module clc_pick #(
  parameter int CONNECTORS = 10
) (
  input  wire logic                  release_request,
  input  wire logic [CONNECTORS-1:0] candidates,
  output logic      [CONNECTORS-1:0] mark
);
  import clc_pkg::*;

  // Isolate the lowest set bit with a two's complement trick.
  always_comb begin
    if (release_request) begin
      mark = candidates & (~candidates + CONNECTORS'(1));
    end else begin
      mark = '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/clc_lane.sv @@
// One connector lane: latch flags, bad-lock and release-wait counters.
`default_nettype none

module clc_lane (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire clc_pkg::lane_ctrl_t       ctrl,
  input  wire logic [clc_pkg::LIM_W-1:0] bad_lock_limit,
  input  wire logic [clc_pkg::LIM_W-1:0] release_timeout,
  output clc_pkg::lane_state_t           state,
  output clc_pkg::lane_result_t          result
);
  import clc_pkg::*;

  logic             locked;
  logic             pending;
  logic [CNT_W-1:0] bad_count;
  logic [CNT_W-1:0] wait_count;
  logic             locked_next;
  logic             pending_next;
  logic [CNT_W-1:0] bad_count_next;
  logic [CNT_W-1:0] wait_count_next;

  logic             rel0;
  logic             lk1;
  logic             done;
  logic             rel1;
  logic             lk2;
  logic [CNT_W-1:0] bad_bumped;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c < CNT_MAX) ? c + CNT_W'(1) : CNT_MAX;
  endfunction

  // Tick update in the order: lock, release handling, bad-lock check.
  always_comb begin
    rel0 = pending | ctrl.mark;
    result.lock_pulse = !rel0 && ctrl.present && !locked;
    lk1 = locked | result.lock_pulse;
    result.unlock_pulse = rel0 && lk1;
    done = rel0 && ((!ctrl.present && lk1) ||
                    (wait_count > {1'b0, release_timeout}));
    rel1 = rel0 && !done;
    lk2 = lk1 && !done;
    if (rel0) begin
      wait_count_next = bump(done ? '0 : wait_count);
    end else begin
      wait_count_next = '0;
    end
    bad_bumped = bump(bad_count);
    pending_next = rel1;
    if (lk2 && !ctrl.present) begin
      if (bad_bumped > {1'b0, bad_lock_limit}) begin
        bad_count_next = '0;
        pending_next = 1'b1;
      end else begin
        bad_count_next = bad_bumped;
      end
    end else begin
      bad_count_next = '0;
    end
    locked_next = lk2;
    // Inactive lanes keep their state and drive no pulses.
    if (!ctrl.active) begin
      result.lock_pulse = 1'b0;
      result.unlock_pulse = 1'b0;
      locked_next = locked;
      pending_next = pending;
      bad_count_next = bad_count;
      wait_count_next = wait_count;
    end
    result.locked_next = locked_next;
    result.pending_next = pending_next;
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      locked <= 1'b0;
      pending <= 1'b0;
      bad_count <= '0;
      wait_count <= '0;
    end else if (accept) begin
      locked <= locked_next;
      pending <= pending_next;
      bad_count <= bad_count_next;
      wait_count <= wait_count_next;
    end
  end

  assign state.locked = locked;
  assign state.pending = pending;

endmodule

`default_nettype wire

@@ rtl/connector_latch_controller_core.sv @@
// Top level of the connector latch controller: lanes, arbiter and result register.
`default_nettype none

// Each connector has its own lane, and all lanes update in the same cycle, so
// the block takes one tick per clock cycle. The result of a tick is held in an
// output register and appears in the cycle after the tick is accepted; a new tick
// is accepted in the same cycle as the waiting result is taken, so only a
// stalled result register holds the input back. The release request is
// resolved by a lowest-set-bit arbiter ahead of the lanes. The configuration
// channel is always ready and its writes take effect on the next tick.
module connector_latch_controller_core #(
  parameter int CONNECTORS = 10
) (
  input wire logic clk,
  input wire logic rst,
  clc_in_if.sink   item_in,
  clc_out_if.source result_out,
  clc_cfg_if.sink  cfg
);
  import clc_pkg::*;

  logic [ACT_W-1:0] active_connectors;
  logic [LIM_W-1:0] bad_lock_limit;
  logic [LIM_W-1:0] release_timeout;

  logic                  accept;
  logic [CONNECTORS-1:0] candidates;
  logic [CONNECTORS-1:0] mark;
  logic [CONNECTORS-1:0] lock_vec;
  logic [CONNECTORS-1:0] unlock_vec;
  logic [CONNECTORS-1:0] locked_vec;
  logic [CONNECTORS-1:0] pending_vec;
  logic [MAP_W-1:0]      lock_map_next;
  logic [MAP_W-1:0]      unlock_map_next;
  logic [MAP_W-1:0]      locked_map_next;
  logic [MAP_W-1:0]      pending_map_next;

  logic             out_valid;
  logic [MAP_W-1:0] lock_pulses;
  logic [MAP_W-1:0] unlock_pulses;
  logic [MAP_W-1:0] locked_map;
  logic [MAP_W-1:0] release_pending_map;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_connectors <= ACTIVE_RESET;
      bad_lock_limit <= LIMIT_RESET;
      release_timeout <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ACTIVE_CONNECTORS: active_connectors <= cfg.data[ACT_W-1:0];
        CFG_BAD_LOCK_LIMIT:    bad_lock_limit <= cfg.data;
        CFG_RELEASE_TIMEOUT:   release_timeout <= cfg.data;
        default: ;
      endcase
    end
  end

  // A tick is taken whenever the result register is free or being emptied.
  assign item_in.ready = !out_valid || result_out.ready;
  assign accept = item_in.valid && item_in.ready;

  clc_pick #(.CONNECTORS(CONNECTORS)) u_pick (
    .release_request(item_in.release_request),
    .candidates     (candidates),
    .mark           (mark)
  );

  // One lane per connector.
  for (genvar i = 0; i < CONNECTORS; i++) begin : g_lane
    lane_ctrl_t   ctrl;
    lane_state_t  st;
    lane_result_t res;
    logic         active;

    assign active = 32'(active_connectors) > i;
    if (i < MAP_W) begin : g_pres
      assign ctrl.present = item_in.presence_map[i];
    end else begin : g_nopres
      assign ctrl.present = 1'b0;
    end
    assign ctrl.active = active;
    assign ctrl.mark = mark[i];
    assign candidates[i] = active && st.locked && !st.pending;

    clc_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .accept         (accept),
      .ctrl           (ctrl),
      .bad_lock_limit (bad_lock_limit),
      .release_timeout(release_timeout),
      .state          (st),
      .result         (res)
    );

    assign lock_vec[i] = res.lock_pulse;
    assign unlock_vec[i] = res.unlock_pulse;
    assign locked_vec[i] = res.locked_next;
    assign pending_vec[i] = res.pending_next;
  end

  // Merge the lane results into the fixed-width maps.
  for (genvar j = 0; j < MAP_W; j++) begin : g_map
    if (j < CONNECTORS) begin : g_used
      assign lock_map_next[j] = lock_vec[j];
      assign unlock_map_next[j] = unlock_vec[j];
      assign locked_map_next[j] = locked_vec[j];
      assign pending_map_next[j] = pending_vec[j];
    end else begin : g_unused
      assign lock_map_next[j] = 1'b0;
      assign unlock_map_next[j] = 1'b0;
      assign locked_map_next[j] = 1'b0;
      assign pending_map_next[j] = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lock_pulses <= lock_map_next;
      unlock_pulses <= unlock_map_next;
      locked_map <= locked_map_next;
      release_pending_map <= pending_map_next;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.lock_pulses = lock_pulses;
  assign result_out.unlock_pulses = unlock_pulses;
  assign result_out.locked_map = locked_map;
  assign result_out.release_pending_map = release_pending_map;

  // The arbiter never marks more than one connector per tick.
  a_single_mark: assert property (@(posedge clk) disable iff (rst)
    $onehot0(mark))
    else $error("release arbiter marked more than one connector");

  // A connector is never driven closed and open in the same tick.
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((lock_pulses & unlock_pulses) == '0))
    else $error("lock and unlock pulse on the same connector");

  // A connector that got a lock pulse reports locked after the tick.
  a_lock_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((lock_pulses & ~locked_map) == '0))
    else $error("lock pulse without locked status");

  // A result is only presented after a tick was accepted.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(accept))
    else $error("result appeared without an accepted tick");

endmodule

`default_nettype wire
